// File: design/utf8_to_utf16_transcoder_macros.svh
// Assertion helpers for the transcoder checker.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Same-cycle implication.
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: design/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned POINT_W = 21;
  localparam int unsigned UNIT_W  = 16;

  localparam logic [UNIT_W-1:0]  REPLACEMENT = 16'hFFFD;
  localparam logic [UNIT_W-1:0]  HI_SURR     = 16'hD800;
  localparam logic [UNIT_W-1:0]  LO_SURR     = 16'hDC00;
  localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h010000;

  // decoded code point handed from front to back
  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic               done;
  } point_word_t;

  typedef enum logic {
    BK_UNIT,
    BK_LOW
  } back_state_t;

endpackage

// File: design/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder. Takes one byte per cycle whenever the point queue
// has room; a code point leaves as one 16-bit word per cycle while out_stall is
// low, or two consecutive words for a surrogate pair, so the output side sets the
// sustained rate only when pairs cluster. A point passes the point queue, then the
// output word register. QUEUE_DEPTH decoded points sit between the byte decoder
// and the unit splitter; in_stall rises only when that queue is full.
module utf8_to_utf16_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_last_of_byte,
  output logic        out_text_done
);

  logic                   q_full;
  logic                   push;
  logic                   pop;
  logic                   head_valid;
  u8u16_pkg::point_word_t push_word;
  u8u16_pkg::point_word_t head_word;

  u8u16_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .push_word      (push_word)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  u8u16_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_word        (head_word),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_code_unit    (out_code_unit),
    .out_last_of_byte (out_last_of_byte),
    .out_text_done    (out_text_done)
  );

endmodule

// File: design/u8u16_front.sv
module u8u16_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_text,
  input  logic                  q_full,
  output logic                  in_stall,
  output logic                  push,
  output u8u16_pkg::point_word_t push_word
);

  logic [1:0]                       pending_r, pending_nxt;
  logic [u8u16_pkg::POINT_W-1:0]    partial_r, partial_nxt;
  logic [u8u16_pkg::POINT_W-1:0]    merged;
  logic [1:0]                       pend_dec;
  logic                             accept;
  logic                             emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pend_dec = pending_r - 2'd1;

  always_comb begin
    case (pending_r)
      2'd1:    merged = partial_r | {15'd0, in_byte[5:0]};
      2'd2:    merged = partial_r | {9'd0, in_byte[5:0], 6'd0};
      default: merged = partial_r | {3'd0, in_byte[5:0], 12'd0};
    endcase
  end

  always_comb begin
    emit            = 1'b0;
    push_word.point = merged;
    push_word.done  = in_end_of_text;
    pending_nxt     = pending_r;
    partial_nxt     = partial_r;
    if (pending_r != 2'd0) begin
      emit        = (pend_dec == 2'd0) || in_end_of_text;
      pending_nxt = pend_dec;
      partial_nxt = (pend_dec == 2'd0) ? '0 : merged;
    end else begin
      unique casez (in_byte)
        8'b0???????: begin
          emit            = 1'b1;
          push_word.point = {13'd0, in_byte};
        end
        8'b110?????: begin
          emit            = in_end_of_text;
          partial_nxt     = {10'd0, in_byte[4:0], 6'd0};
          push_word.point = partial_nxt;
          pending_nxt     = 2'd1;
        end
        8'b1110????: begin
          emit            = in_end_of_text;
          partial_nxt     = {5'd0, in_byte[3:0], 12'd0};
          push_word.point = partial_nxt;
          pending_nxt     = 2'd2;
        end
        8'b11110???: begin
          emit            = in_end_of_text;
          partial_nxt     = {in_byte[2:0], 18'd0};
          push_word.point = partial_nxt;
          pending_nxt     = 2'd3;
        end
        default: begin
          emit            = 1'b1;
          push_word.point = {5'd0, u8u16_pkg::REPLACEMENT};
        end
      endcase
    end
    if (in_end_of_text) begin
      pending_nxt = 2'd0;
      partial_nxt = '0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      partial_r <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// File: design/u8u16_queue.sv
module u8u16_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  u8u16_pkg::point_word_t push_word,
  input  logic                   pop,
  output logic                   full,
  output logic                   head_valid,
  output u8u16_pkg::point_word_t head_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8u16_pkg::point_word_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_word  = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: design/u8u16_back.sv
module u8u16_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  u8u16_pkg::point_word_t head_word,
  output logic                   pop,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [15:0]            out_code_unit,
  output logic                   out_last_of_byte,
  output logic                   out_text_done
);

  u8u16_pkg::back_state_t state_r, state_nxt;

  logic                          valid_r, valid_nxt;
  logic [15:0]                   unit_r, unit_nxt;
  logic                          last_r, last_nxt;
  logic                          done_r, done_nxt;
  logic [15:0]                   low_r, low_nxt;
  logic                          low_done_r, low_done_nxt;
  logic                          load;
  logic                          big;
  logic [u8u16_pkg::POINT_W-1:0] offs;

  assign load = !valid_r || !out_stall;
  assign big  = (head_word.point[20:16] != 5'd0);
  assign offs = head_word.point - u8u16_pkg::SUPP_BASE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      u8u16_pkg::BK_UNIT: begin
        if (load && head_valid && big) begin
          state_nxt = u8u16_pkg::BK_LOW;
        end
      end
      u8u16_pkg::BK_LOW: begin
        if (load) begin
          state_nxt = u8u16_pkg::BK_UNIT;
        end
      end
      default: state_nxt = u8u16_pkg::BK_UNIT;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    valid_nxt    = valid_r;
    unit_nxt     = unit_r;
    last_nxt     = last_r;
    done_nxt     = done_r;
    low_nxt      = low_r;
    low_done_nxt = low_done_r;
    unique case (state_r)
      u8u16_pkg::BK_UNIT: begin
        if (load) begin
          valid_nxt = head_valid;
          pop       = head_valid;
          if (big) begin
            unit_nxt     = u8u16_pkg::HI_SURR + {5'd0, offs[20:10]};
            last_nxt     = 1'b0;
            done_nxt     = 1'b0;
            low_nxt      = u8u16_pkg::LO_SURR | {6'd0, offs[9:0]};
            low_done_nxt = head_word.done;
          end else begin
            unit_nxt = head_word.point[15:0];
            last_nxt = 1'b1;
            done_nxt = head_word.done;
          end
        end
      end
      u8u16_pkg::BK_LOW: begin
        if (load) begin
          valid_nxt = 1'b1;
          unit_nxt  = low_r;
          last_nxt  = 1'b1;
          done_nxt  = low_done_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8u16_pkg::BK_UNIT;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    last_r     <= last_nxt;
    done_r     <= done_nxt;
    low_r      <= low_nxt;
    low_done_r <= low_done_nxt;
  end

  assign out_valid        = valid_r;
  assign out_code_unit    = unit_r;
  assign out_last_of_byte = last_r;
  assign out_text_done    = done_r;

endmodule

// File: design/u8u16_checker.sv
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        in_end_of_text,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_code_unit,
  input logic        out_last_of_byte,
  input logic        out_text_done
);

  // stalled input word stays offered and unchanged
  `U8U16_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                    in_valid && $stable(in_byte) && $stable(in_end_of_text))

  // stalled word stays offered
  `U8U16_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // end of text only on the last word of a byte
  `U8U16_ASSERT_IMP(a_done_last, clk, rst_n, out_valid && out_text_done, out_last_of_byte)

  // only a high half (D800..DFBF) is followed by another word of the same byte
  `U8U16_ASSERT_IMP(a_hi_only, clk, rst_n, out_valid && !out_last_of_byte,
                    out_code_unit[15:11] == 5'b11011)

  // low half follows a taken high half immediately
  `U8U16_ASSERT_NXT(a_low_next, clk, rst_n, out_valid && !out_stall && !out_last_of_byte,
                    out_valid && out_last_of_byte && (out_code_unit[15:10] == 6'b110111))

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_byte          (in_byte),
  .in_end_of_text   (in_end_of_text),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_code_unit    (out_code_unit),
  .out_last_of_byte (out_last_of_byte),
  .out_text_done    (out_text_done)
);

// File: tb/sv/utf8_to_utf16_transcoder_test.sv
module utf8_to_utf16_transcoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        done;
  } utf16_word_t;

  typedef enum {
    CH_ASCII,
    CH_TWO,
    CH_THREE,
    CH_FOUR,
    CH_TRUNC,
    CH_BAD_CONT,
    CH_STRAY,
    CH_BAD_LEAD,
    CH_NOISE
  } char_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_last_of_byte;
  logic        out_text_done;

  text_byte_t  text_q[$];
  utf16_word_t unit_q[$];

  logic [1:0]  pend_count = 2'd0;
  logic [20:0] point_acc = 21'd0;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 77;
  bit          hold_req = 1'b0;
  logic        rcv_hold = 1'b0;
  int          errors = 0;

  utf8_to_utf16_transcoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_unit    (out_code_unit),
    .out_last_of_byte (out_last_of_byte),
    .out_text_done    (out_text_done)
  );

  always #5ns clk = ~clk;

  function automatic void expect_point(logic [20:0] cp, logic done);
    logic [20:0] rel;
    if (cp > 21'h00FFFF) begin
      rel = cp - u8u16_pkg::SUPP_BASE;
      unit_q.push_back('{u8u16_pkg::HI_SURR + 16'(rel >> 10), 1'b0, 1'b0});
      unit_q.push_back('{u8u16_pkg::LO_SURR + {6'd0, rel[9:0]}, 1'b1, done});
    end else begin
      unit_q.push_back('{cp[15:0], 1'b1, done});
    end
  endfunction

  function automatic void predict_units(logic [7:0] b, logic eot);
    if (pend_count != 2'd0) begin
      point_acc = point_acc | (21'(b[5:0]) << (6 * (int'(pend_count) - 1)));
      pend_count = pend_count - 2'd1;
      if (pend_count == 2'd0 || eot) expect_point(point_acc, eot);
    end else if (!b[7]) begin
      expect_point(21'(b), eot);
    end else if (b[7:5] == 3'b110) begin
      point_acc = 21'(b[4:0]) << 6;
      pend_count = 2'd1;
      if (eot) expect_point(point_acc, eot);
    end else if (b[7:4] == 4'b1110) begin
      point_acc = 21'(b[3:0]) << 12;
      pend_count = 2'd2;
      if (eot) expect_point(point_acc, eot);
    end else if (b[7:3] == 5'b11110) begin
      point_acc = 21'(b[2:0]) << 18;
      pend_count = 2'd3;
      if (eot) expect_point(point_acc, eot);
    end else begin
      unit_q.push_back('{u8u16_pkg::REPLACEMENT, 1'b1, eot});
    end
    if (pend_count == 2'd0) point_acc = 21'd0;
    if (eot) begin
      pend_count = 2'd0;
      point_acc = 21'd0;
    end
  endfunction

  function automatic void push_byte(logic [7:0] value, logic eot);
    text_q.push_back('{value, eot});
  endfunction

  function automatic void queue_char(char_kind_t kind, logic eot);
    logic [20:0] cp;
    logic [7:0]  seq [4];
    int          len;
    int          keep;
    int          i;
    len = 1;
    cp = 21'($urandom);
    case (kind)
      CH_ASCII:    seq[0] = {1'b0, cp[6:0]};
      CH_STRAY:    seq[0] = {2'b10, cp[5:0]};
      CH_BAD_LEAD: seq[0] = {5'b11111, cp[2:0]};
      CH_NOISE:    seq[0] = cp[7:0];
      default: begin
        len = (kind == CH_TWO) ? 2 : (kind == CH_THREE) ? 3 :
              (kind == CH_FOUR) ? 4 : int'($urandom_range(2, 4));
        cp = cp & ((21'd1 << (5 * len + 1)) - 21'd1);
        if (len == 4 && $urandom_range(3) != 0)
          cp = 21'h010000 + 21'($urandom_range(0, 'hFFFFF));
        case (len)
          2:       seq[0] = {3'b110, cp[10:6]};
          3:       seq[0] = {4'b1110, cp[15:12]};
          default: seq[0] = {5'b11110, cp[20:18]};
        endcase
        for (i = 1; i < len; i++) seq[i] = {2'b10, 6'(cp >> (6 * (len - 1 - i)))};
        if (kind == CH_BAD_CONT) begin
          i = $urandom_range(1, len - 1);
          seq[i][7:6] = 2'($urandom);
        end
      end
    endcase
    keep = (kind == CH_TRUNC) ? int'($urandom_range(1, len - 1)) : len;
    for (i = 0; i < keep; i++) push_byte(seq[i], eot && i == keep - 1);
  endfunction

  function automatic void fill_random(int n);
    int         r;
    char_kind_t kind;
    while (text_q.size() < n) begin
      r = $urandom_range(99);
      if (r < 20)      kind = CH_ASCII;
      else if (r < 40) kind = CH_TWO;
      else if (r < 58) kind = CH_THREE;
      else if (r < 74) kind = CH_FOUR;
      else if (r < 80) kind = CH_TRUNC;
      else if (r < 86) kind = CH_BAD_CONT;
      else if (r < 91) kind = CH_STRAY;
      else if (r < 95) kind = CH_BAD_LEAD;
      else             kind = CH_NOISE;
      queue_char(kind, $urandom_range(11) == 0);
    end
  endfunction

  task automatic drain();
    do @(negedge clk); while (text_q.size() != 0 || unit_q.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_units(in_byte, in_end_of_text);
        void'(text_q.pop_front());
      end
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte <= text_q[0].value;
        in_end_of_text <= text_q[0].eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_units
    utf16_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (unit_q.size() == 0) begin
          $error("unexpected word: code_unit %h", out_code_unit);
          errors++;
        end else begin
          want = unit_q.pop_front();
          if (out_code_unit !== want.unit) begin
            $error("code_unit mismatch: expected %h, actual %h", want.unit, out_code_unit);
            errors++;
          end
          if (out_last_of_byte !== want.last) begin
            $error("last_of_byte mismatch: expected %b, actual %b", want.last,
                   out_last_of_byte);
            errors++;
          end
          if (out_text_done !== want.done) begin
            $error("text_done mismatch: expected %b, actual %b", want.done, out_text_done);
            errors++;
          end
        end
      end
      out_stall <= rcv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long receiver hold-off so the point queue fills and backs up the input
  initial begin
    wait (hold_req);
    @(posedge clk);
    rcv_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rcv_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("utf8_to_utf16_transcoder regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hDF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // overlong zero
    push_byte(8'hE0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    // encoded surrogate
    push_byte(8'hED, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // beyond 10FFFF
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b1);
    // non-continuation byte in a continuation slot
    push_byte(8'hC3, 1'b0);
    push_byte(8'h41, 1'b0);
    // text ends mid-sequence
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'hF0, 1'b1);

    fill_random(430);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 34;
    fill_random(430);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(430);
    hold_req = 1'b1;
    drain();

    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("utf8_to_utf16_transcoder regression: pass");
    end else begin
      $display("utf8_to_utf16_transcoder regression: fail");
    end
    $finish;
  end

endmodule
